@@ rtl/core/rdh_pkg.sv @@
// radix digit histogram: shared types, constants and helper functions
// used by rdh_ctrl, rdh_dpath and the top level; depends on nothing
`timescale 1ns / 1ps

package rdh_pkg;

  localparam int DIGIT_BITS = 12;
  localparam int NUM_BINS   = 1 << DIGIT_BITS;
  localparam int KEY_W      = 32;
  localparam int SEL_W      = 12;
  localparam int COUNT_W    = 32;
  localparam int SHIFT_W    = 5;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(20);

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef logic [DIGIT_BITS-1:0] addr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [SHIFT_W-1:0]    shift_t;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [SEL_W-1:0] bin_select;
  } req_t;

  typedef struct packed {
    logic [SEL_W-1:0] bin_index;
    count_t           bin_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic update_wr;
    logic load_rsp;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_read;
    logic rsp_free;
  } dp_status_t;

  function automatic addr_t key_digit(input logic [KEY_W-1:0] key, input shift_t shift);
    addr_t digit;
    digit = addr_t'(key >> shift);
    return digit;
  endfunction

  function automatic addr_t sel_to_addr(input logic [SEL_W-1:0] sel);
    addr_t a;
    a = addr_t'(sel);
    return a;
  endfunction

  function automatic logic [SEL_W-1:0] addr_to_sel(input addr_t a);
    logic [SEL_W-1:0] s;
    s = SEL_W'(a);
    return s;
  endfunction

endpackage

@@ rtl/core/rdh_ram.sv @@
// generic single write, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rdh_ctrl.sv @@
// radix digit histogram controller: clearing pass, accept, read-modify-write
// depends on rdh_pkg
`timescale 1ns / 1ps

module rdh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rdh_pkg::dp_status_t status,
  output rdh_pkg::dp_cmd_t    ctl
);
  import rdh_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       can_update;

  assign req_stall  = (state != ST_IDLE);
  assign can_update = !status.is_read || status.rsp_free;

  always_comb begin
    ctl.accept    = (state == ST_IDLE) && req_valid;
    ctl.clear_wr  = (state == ST_CLEAR);
    ctl.update_wr = (state == ST_UPDATE) && can_update;
    ctl.load_rsp  = (state == ST_UPDATE) && status.is_read && status.rsp_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (can_update) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/rdh_dpath.sv @@
// radix digit histogram datapath: shift register, digit extract, bin ram,
// clear counter and result register; depends on rdh_pkg and rdh_ram
`timescale 1ns / 1ps

module rdh_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  rdh_pkg::shift_t     cfg_data,
  input  rdh_pkg::req_t       req,
  input  rdh_pkg::dp_cmd_t    ctl,
  output rdh_pkg::dp_status_t status,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rdh_pkg::rsp_t       rsp
);
  import rdh_pkg::*;

  shift_t digit_shift;
  addr_t  clr_addr;
  addr_t  item_addr;
  logic   item_cmd;
  addr_t  req_addr;
  addr_t  raddr;
  addr_t  waddr;
  count_t wdata;
  count_t rdata;
  logic   we;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_shift <= SHIFT_RESET;
    end else if (cfg_write) begin
      digit_shift <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_wr) begin
      clr_addr <= clr_addr + addr_t'(1);
    end
  end

  assign req_addr = (req.cmd == CMD_READ) ? sel_to_addr(req.bin_select)
                                          : key_digit(req.key, digit_shift);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_addr <= req_addr;
      item_cmd  <= req.cmd;
    end
  end

  assign raddr = ctl.accept ? req_addr : item_addr;
  assign we    = ctl.clear_wr || ctl.update_wr;
  assign waddr = ctl.clear_wr ? clr_addr : item_addr;
  assign wdata = (ctl.clear_wr || item_cmd == CMD_READ) ? '0 : rdata + count_t'(1);

  rdh_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_rsp) begin
      rsp.bin_index <= addr_to_sel(item_addr);
      rsp.bin_count <= rdata;
    end
  end

  always_comb begin
    status.clear_last = (clr_addr == '1);
    status.is_read    = (item_cmd == CMD_READ);
    status.rsp_free   = !rsp_valid || !rsp_stall;
  end

endmodule

@@ rtl/core/radix_digit_histogram.sv @@
// radix digit histogram top level: a word is accepted in idle, then its bin
// is read-modify-written through the registered ram read port before the
// next word is taken; a read word's result is loaded when the output is free
// reset (synchronous, active high) starts a clearing pass over all 2^DIGIT_BITS
// bins (4096) during which req_stall stays high; cfg writes are taken always
// depends on rdh_pkg, rdh_ctrl, rdh_dpath, rdh_ram
`timescale 1ns / 1ps

module radix_digit_histogram (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  rdh_pkg::shift_t cfg_data,
  input  logic            req_valid,
  output logic            req_stall,
  input  rdh_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output rdh_pkg::rsp_t   rsp
);
  import rdh_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t status;

  rdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .status   (status),
    .ctl      (ctl)
  );

  rdh_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .req      (req),
    .ctl      (ctl),
    .status   (status),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("accepted word did not block the next one");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_wr |-> req_stall && !ctl.update_wr)
    else $error("word taken during clearing pass");

  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(ctl.load_rsp) && $past(status.is_read))
    else $error("result without a read word");

endmodule

@@ tb/sv/radix_digit_histogram_tb.sv @@
// testbench for radix_digit_histogram: a directed table, then constrained-random
// count and read words at several digit shifts, checked against a local histogram
// depends on rdh_pkg and radix_digit_histogram
`timescale 1ns / 1ps

module radix_digit_histogram_tb;
  import rdh_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_PAD   = 8;
  localparam int RAND_WORDS  = 88;
  localparam int NUM_PHASES  = 8;
  localparam int POOL_SIZE   = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [11:0] sel;
    logic        has_count;
    logic [31:0] count;
  } dir_row_t;

  localparam int NUM_ROWS = 21;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{CMD_READ,  32'h0000_0000, 12'h000, 1'b1, 32'd0},
    '{CMD_READ,  32'hFFFF_FFFF, 12'hFFF, 1'b1, 32'd0},
    '{CMD_COUNT, 32'hFFFF_FFFF, 12'h000, 1'b0, 32'd0},
    '{CMD_COUNT, 32'hFFFF_FFFF, 12'hFFF, 1'b0, 32'd0},
    '{CMD_READ,  32'h0000_0000, 12'hFFF, 1'b1, 32'd2},
    '{CMD_READ,  32'h0000_0000, 12'hFFF, 1'b1, 32'd0},
    '{CMD_COUNT, 32'h0000_0000, 12'hFFF, 1'b0, 32'd0},
    '{CMD_READ,  32'hFFFF_FFFF, 12'h000, 1'b1, 32'd1},
    '{CMD_COUNT, 32'h0010_0000, 12'h000, 1'b0, 32'd0},
    '{CMD_COUNT, 32'h8000_0000, 12'h000, 1'b0, 32'd0},
    '{CMD_COUNT, 32'h000F_FFFF, 12'h000, 1'b0, 32'd0},
    '{CMD_COUNT, 32'h1234_5678, 12'h000, 1'b0, 32'd0},
    '{CMD_READ,  32'h0000_0000, 12'h001, 1'b1, 32'd1},
    '{CMD_READ,  32'h0000_0000, 12'h800, 1'b1, 32'd1},
    '{CMD_READ,  32'h0000_0000, 12'h000, 1'b1, 32'd1},
    '{CMD_READ,  32'h0000_0000, 12'h123, 1'b1, 32'd1},
    '{CMD_COUNT, 32'hAAAA_AAAA, 12'h555, 1'b0, 32'd0},
    '{CMD_COUNT, 32'h5555_5555, 12'hAAA, 1'b0, 32'd0},
    '{CMD_READ,  32'h5555_5555, 12'hAAA, 1'b0, 32'd0},
    '{CMD_READ,  32'hAAAA_AAAA, 12'h555, 1'b0, 32'd0},
    '{CMD_READ,  32'h0000_0000, 12'h7FF, 1'b1, 32'd0}
  };

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   cfg_write = 1'b0;
  shift_t cfg_data  = SHIFT_RESET;
  logic   req_valid = 1'b0;
  logic   req_stall;
  req_t   req       = '0;
  logic   rsp_valid;
  logic   rsp_stall = 1'b0;
  rsp_t   rsp;

  count_t bin_tally [NUM_BINS];
  shift_t cur_shift;
  rsp_t   pending_reads [$];
  addr_t  hot_bins [POOL_SIZE];
  int     mismatches = 0;
  int     cycles     = 0;
  int     stall_left = 0;
  bit     quiet      = 1'b0;

  radix_digit_histogram dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // histogram update; returns 1 with the reported bin when the word is a read
  function automatic bit hist_apply(input req_t w, output rsp_t r);
    addr_t a;
    r = '0;
    if (w.cmd == CMD_COUNT) begin
      a = addr_t'(w.key >> cur_shift);
      bin_tally[a] = bin_tally[a] + 32'd1;
      return 1'b0;
    end
    a = addr_t'(w.bin_select);
    r.bin_index = a;
    r.bin_count = bin_tally[a];
    bin_tally[a] = '0;
    return 1'b1;
  endfunction

  task automatic send_word(input req_t w, input bit has_count, input count_t count);
    int   gap;
    rsp_t r;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (hist_apply(w, r)) begin
      if (has_count) r.bin_count = count;
      pending_reads.push_back(r);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic set_shift(input shift_t s);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_shift = s;
  endtask

  function automatic req_t random_word();
    req_t w;
    int   r;
    w.key = $urandom;
    w.bin_select = SEL_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      w.cmd = CMD_COUNT;
      if (r < 45)
        w.key = (w.key & ~(32'hFFF << cur_shift))
              | (32'(hot_bins[$urandom_range(0, POOL_SIZE-1)]) << cur_shift);
    end else begin
      w.cmd = CMD_READ;
      if (r < 85) w.bin_select = hot_bins[$urandom_range(0, POOL_SIZE-1)];
    end
    return w;
  endfunction

  // response side: cycle limit, random stall and the scoreboard check
  always @(posedge clk) begin
    rsp_t want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected word: index %0h count %0h", rsp.bin_index, rsp.bin_count);
        end else begin
          want = pending_reads.pop_front();
          if (rsp.bin_index !== want.bin_index || rsp.bin_count !== want.bin_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected index %0h count %0h, got index %0h count %0h",
                       want.bin_index, want.bin_count, rsp.bin_index, rsp.bin_count);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        rsp_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    req_t   w;
    shift_t s;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    cur_shift = SHIFT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = (p % 3 == 1);
      unique case (p)
        0: s = SHIFT_RESET;
        1: s = 5'd0;
        2: s = 5'd31;
        3: s = 5'd12;
        4: s = 5'd1;
        5: s = 5'd30;
        default: s = shift_t'($urandom_range(0, 31));
      endcase
      if (p > 0) set_shift(s);
      if (p == 0) begin
        for (int i = 0; i < NUM_ROWS; i++) begin
          w.cmd = DIR_ROWS[i].cmd;
          w.key = DIR_ROWS[i].key;
          w.bin_select = DIR_ROWS[i].sel;
          send_word(w, DIR_ROWS[i].has_count, DIR_ROWS[i].count);
        end
      end
      foreach (hot_bins[i]) hot_bins[i] = addr_t'($urandom);
      hot_bins[0] = '0;
      hot_bins[1] = '1;
      for (int i = 0; i < RAND_WORDS; i++)
        send_word(random_word(), 1'b0, '0);
      drain();
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
